/* sv/telnet_command_line_parser_assert.svh */
// -----------------------------------------------------------------------------
// Telnet command line parser assertion macros
// Concurrent assertion helpers, clocked on clk and disabled during arst_n low.
// -----------------------------------------------------------------------------
`ifndef TELNET_COMMAND_LINE_PARSER_ASSERT_SVH
`define TELNET_COMMAND_LINE_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define TCLP_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tclp assertion failed");

// Check that a condition never holds outside reset.
`define TCLP_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("tclp forbidden condition seen");

`else

`define TCLP_ASSERT(label, prop)
`define TCLP_ASSERT_NEVER(label, cond)

`endif

`endif

/* sv/tclp_pkg.sv */
// -----------------------------------------------------------------------------
// Telnet command line parser package
// Byte codes, telnet phases, result kinds and the result word type.
// -----------------------------------------------------------------------------
package tclp_pkg;

	localparam int unsigned COUNT_W = 10;
	localparam logic [COUNT_W-1:0] LINE_BYTES = 10'd512;

	localparam logic [7:0] B_EOT   = 8'h04;
	localparam logic [7:0] B_LF    = 8'h0A;
	localparam logic [7:0] B_CR    = 8'h0D;
	localparam logic [7:0] B_SPACE = 8'h20;
	localparam logic [7:0] B_DEL   = 8'h7F;
	localparam logic [7:0] T_IAC   = 8'hFF;
	localparam logic [7:0] T_DONT  = 8'hFE;
	localparam logic [7:0] T_DO    = 8'hFD;
	localparam logic [7:0] T_WONT  = 8'hFC;
	localparam logic [7:0] T_WILL  = 8'hFB;
	localparam logic [7:0] T_EL    = 8'hF8;
	localparam logic [7:0] T_AYT   = 8'hF6;
	localparam logic [7:0] T_IP    = 8'hF4;
	localparam logic [7:0] OPT_TM  = 8'h06;
	localparam logic [7:0] OPT_SGA = 8'h03;

	typedef enum logic [1:0] {
		PH_PLAIN = 2'd0,
		PH_IAC   = 2'd1,
		PH_DO    = 2'd2,
		PH_SKIP  = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		K_DROP   = 3'd0,
		K_CHAR   = 3'd1,
		K_END    = 3'd2,
		K_ERASE  = 3'd3,
		K_LOGOUT = 3'd4,
		K_TM     = 3'd5,
		K_SGA    = 3'd6,
		K_AYT    = 3'd7
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       forced;
	} result_t;

endpackage

/* sv/tclp_classify.sv */
// -----------------------------------------------------------------------------
// Telnet command line byte classifier
// Holds the telnet phase, line-end swallow flag and raw byte count, and
// classifies one byte per fire.
// -----------------------------------------------------------------------------
`include "telnet_command_line_parser_assert.svh"

module tclp_classify import tclp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] rx_byte,
	output result_t    res
);

	phase_t               phase_q, phase_d;
	logic                 skip_q, skip_d;
	logic [COUNT_W-1:0]   count_q, count_d;
	logic [COUNT_W-1:0]   count_inc;
	logic                 is_line_end;
	logic                 swallow;
	logic                 ended;
	kind_t                kind;

	assign is_line_end = (rx_byte == B_CR) || (rx_byte == B_LF);
	assign swallow     = skip_q && is_line_end;
	assign count_inc   = count_q + COUNT_W'(1);

	always_comb begin
		kind    = K_DROP;
		ended   = 1'b0;
		phase_d = phase_q;
		case (phase_q)
			PH_PLAIN: begin
				if (rx_byte == T_IAC) begin
					phase_d = PH_IAC;
				end else if (is_line_end || rx_byte == B_EOT) begin
					kind  = K_END;
					ended = 1'b1;
				end else if (rx_byte < B_SPACE || rx_byte == B_DEL) begin
					kind = K_DROP;
				end else begin
					kind = K_CHAR;
				end
			end
			PH_IAC: begin
				phase_d = PH_PLAIN;
				if (rx_byte == T_IP) begin
					kind = K_LOGOUT;
				end else if (rx_byte == T_DO) begin
					phase_d = PH_DO;
				end else if (rx_byte == T_WILL || rx_byte == T_WONT
						|| rx_byte == T_DONT) begin
					phase_d = PH_SKIP;
				end else if (rx_byte == T_AYT) begin
					kind = K_AYT;
				end else if (rx_byte == T_EL) begin
					kind = K_ERASE;
				end
			end
			PH_DO: begin
				phase_d = PH_PLAIN;
				if (rx_byte == OPT_TM) begin
					kind = K_TM;
				end else if (rx_byte == OPT_SGA) begin
					kind = K_SGA;
				end
			end
			default: begin
				phase_d = PH_PLAIN;
			end
		endcase
	end

	always_comb begin
		res.kind   = kind;
		res.ch     = (kind == K_CHAR) ? rx_byte : 8'h00;
		res.forced = 1'b0;
		skip_d     = 1'b0;
		count_d    = count_inc;
		if (swallow) begin
			// hold all state, drop the byte
			res.kind = K_DROP;
			res.ch   = 8'h00;
			skip_d   = 1'b1;
			count_d  = count_q;
		end else if (kind == K_LOGOUT) begin
			count_d = '0;
		end else if (ended) begin
			count_d = '0;
			skip_d  = 1'b1;
		end else if (count_inc >= LINE_BYTES) begin
			res.forced = 1'b1;
			count_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			skip_q  <= 1'b0;
			count_q <= '0;
		end else if (fire) begin
			if (!swallow) begin
				phase_q <= (kind == K_LOGOUT) ? PH_PLAIN : phase_d;
			end
			skip_q  <= skip_d;
			count_q <= count_d;
		end
	end

	`TCLP_ASSERT(a_forced_clears_count, fire && res.forced |=> count_q == '0)
	`TCLP_ASSERT(a_swallow_keeps_skip, fire && swallow |=> skip_q && $stable(count_q))
	`TCLP_ASSERT(a_logout_resets, fire && res.kind == K_LOGOUT |=> phase_q == PH_PLAIN && !skip_q && count_q == '0)
	`TCLP_ASSERT_NEVER(a_forced_not_on_end, res.forced && (res.kind == K_END || res.kind == K_LOGOUT))

endmodule

/* sv/telnet_command_line_parser.sv */
// -----------------------------------------------------------------------------
// Telnet command line parser
// Classifies received bytes for a command-line assembler: keep, drop, end,
// telnet commands and forced end when the raw byte count reaches capacity.
// -----------------------------------------------------------------------------
// Path: an accepted word is held in the input register, then classified into
//   the result register, which drives the result ports.
// Throughput: one word per cycle; the input register and the result
//   register advance together whenever the result register is free.
// Reset: arst_n clears both stage valids, the telnet phase, the line-end
//   swallow flag and the byte count; no clearing pass is needed.

module telnet_command_line_parser import tclp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [2:0] kind,
	output logic [7:0] char_out,
	output logic       forced_end
);

	// Input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	// Result register stage
	logic       valid_s2;
	result_t    res_s2;

	logic       adv_s2;
	logic       fire;
	logic       take_in;
	result_t    res;

	// The result register is free when empty or being drained this cycle.
	assign adv_s2  = !valid_s2 || !res_stall;
	// Classify the held byte only when its result can be written.
	assign fire    = valid_s1 && adv_s2;
	// Take a new word when the input register is empty or moves on.
	assign rx_stall = valid_s1 && !adv_s2;
	assign take_in  = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= rx_byte;
		end
	end

	// Classifier owns the parser state; it advances only on fire.
	tclp_classify u_classify (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.rx_byte (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	// Drive the result ports straight from the result register.
	assign res_valid  = valid_s2;
	assign kind       = res_s2.kind;
	assign char_out   = res_s2.ch;
	assign forced_end = res_s2.forced;

endmodule

/* sim/telnet_command_line_parser_checker.sv */
// -----------------------------------------------------------------------------
// Telnet command line parser checker
// Watches both channels, classifies every accepted input byte with its own
// copy of the parser state and compares each result word with the oldest
// classification still waiting.
// -----------------------------------------------------------------------------
module telnet_command_line_parser_checker import tclp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	input  logic       rx_stall,
	input  logic [7:0] rx_byte,
	input  logic       res_valid,
	input  logic       res_stall,
	input  logic [2:0] kind,
	input  logic [7:0] char_out,
	input  logic       forced_end,
	output int         fails,
	output int         waiting,
	output int         checked,
	output int         forced_seen,
	output logic [7:0] kinds_seen
);

	timeunit 1ns;
	timeprecision 1ps;

	phase_t             tel_phase;
	logic               swallow_ends;
	logic [COUNT_W-1:0] raw_count;
	result_t            predicted_classes[$];

	// Classify one byte and advance the parser state.
	function automatic result_t classify_byte(input logic [7:0] b);
		result_t r;
		logic    ended;
		r.kind   = K_DROP;
		r.ch     = 8'h00;
		r.forced = 1'b0;
		ended    = 1'b0;
		if (swallow_ends && (b == B_CR || b == B_LF))
			return r;
		swallow_ends = 1'b0;
		case (tel_phase)
		PH_PLAIN: begin
			if (b == T_IAC)
				tel_phase = PH_IAC;
			else if (b == B_CR || b == B_LF || b == B_EOT) begin
				r.kind = K_END;
				ended  = 1'b1;
			end else if (b < B_SPACE || b == B_DEL)
				r.kind = K_DROP;
			else begin
				r.kind = K_CHAR;
				r.ch   = b;
			end
		end
		PH_IAC: begin
			tel_phase = PH_PLAIN;
			case (b)
			T_IP:                  r.kind = K_LOGOUT;
			T_DO:                  tel_phase = PH_DO;
			T_WILL, T_WONT, T_DONT: tel_phase = PH_SKIP;
			T_AYT:                 r.kind = K_AYT;
			T_EL:                  r.kind = K_ERASE;
			default:               ;
			endcase
		end
		PH_DO: begin
			if (b == OPT_TM)
				r.kind = K_TM;
			else if (b == OPT_SGA)
				r.kind = K_SGA;
			tel_phase = PH_PLAIN;
		end
		default: tel_phase = PH_PLAIN;
		endcase
		if (r.kind == K_LOGOUT) begin
			tel_phase    = PH_PLAIN;
			swallow_ends = 1'b0;
			raw_count    = '0;
		end else if (ended) begin
			raw_count    = '0;
			tel_phase    = PH_PLAIN;
			swallow_ends = 1'b1;
		end else begin
			raw_count = raw_count + COUNT_W'(1);
			if (raw_count >= LINE_BYTES) begin
				r.forced  = 1'b1;
				raw_count = '0;
			end
		end
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		fails++;
		$display("tb: %s mismatch at word %0d: got %0d, expected %0d",
			what, checked, got, want);
	endtask

	// Pop before push: a result never belongs to a byte taken at the same edge.
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			tel_phase    = PH_PLAIN;
			swallow_ends = 1'b0;
			raw_count    = '0;
			predicted_classes.delete();
			fails        = 0;
			waiting      = 0;
			checked      = 0;
			forced_seen  = 0;
			kinds_seen   = 8'h00;
		end else begin
			if (res_valid && !res_stall) begin
				checked++;
				if (predicted_classes.size() == 0)
					report("unexpected word", int'(kind), -1);
				else begin
					want = predicted_classes.pop_front();
					if (kind !== want.kind)
						report("kind", int'(kind), int'(want.kind));
					if (char_out !== want.ch)
						report("char_out", int'(char_out), int'(want.ch));
					if (forced_end !== want.forced)
						report("forced_end", int'(forced_end), int'(want.forced));
					kinds_seen[want.kind] = 1'b1;
					if (want.forced)
						forced_seen++;
				end
			end
			if (rx_valid && !rx_stall)
				predicted_classes.push_back(classify_byte(rx_byte));
			waiting = predicted_classes.size();
		end
	end

endmodule

/* sim/telnet_command_line_parser_tb.sv */
// -----------------------------------------------------------------------------
// Telnet command line parser testbench
// Feeds directed and random byte streams (text lines, terminators, telnet
// sequences, noise and a line up to capacity) with random gaps and stalls on
// both channels; a checker beside the parser predicts and compares results.
// -----------------------------------------------------------------------------
module telnet_command_line_parser_tb;

	import tclp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Cycles without any handshake before the run is declared hung. The
	// longest legal quiet stretch is the receiver's hold-off plus a sender gap.
	localparam int IDLE_LIMIT = 1000;
	localparam int RANDOM_BYTES = 80;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       rx_valid;
	logic       rx_stall;
	logic [7:0] rx_byte;
	logic       res_valid;
	logic       res_stall;
	logic [2:0] kind;
	logic [7:0] char_out;
	logic       forced_end;

	int         fails;
	int         words_waiting;
	int         words_checked;
	int         forced_seen;
	logic [7:0] kinds_seen;

	int         bytes_sent;
	bit         sender_steady;
	int         idle_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	telnet_command_line_parser uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.kind       (kind),
		.char_out   (char_out),
		.forced_end (forced_end)
	);

	telnet_command_line_parser_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_stall    (rx_stall),
		.rx_byte     (rx_byte),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.kind        (kind),
		.char_out    (char_out),
		.forced_end  (forced_end),
		.fails       (fails),
		.waiting     (words_waiting),
		.checked     (words_checked),
		.forced_seen (forced_seen),
		.kinds_seen  (kinds_seen)
	);

	// Offer one word: optionally drop valid for a random gap, then hold the
	// byte until the parser takes it. Steady mode switches now and then so
	// that there are also long runs with no gaps at all.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if ($urandom_range(0, 39) == 0)
			sender_steady = !sender_steady;
		gap = sender_steady ? 0 : int'($urandom_range(0, 7));
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (rx_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Printable ASCII or a byte above DEL other than IAC: always kept.
	function automatic logic [7:0] text_byte();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(8'h20, 8'h7E));
		return 8'($urandom_range(8'h80, 8'hFE));
	endfunction

	// Start a fresh command, then fill it with filler bytes that neither end
	// it nor open a telnet sequence, and finish with the given byte.
	task automatic send_long_line(input int fill, input logic [7:0] last);
		logic [7:0] b;
		// 'x' pulls any pending telnet phase back to plain data and clears
		// the swallow flag, so the LF that follows really ends the command.
		send_byte(8'h78);
		send_byte(B_LF);
		repeat (fill) begin
			b = 8'($urandom_range(0, 254));
			if (b == B_CR || b == B_LF || b == B_EOT)
				b = 8'h61;
			send_byte(b);
		end
		send_byte(last);
	endtask

	// One random chunk of traffic. Mostly well-formed: text lines with
	// assorted terminators and complete telnet commands. The rest is control
	// bytes, plain noise and telnet sequences cut short.
	task automatic send_random_sequence();
		int pick;
		int n;
		pick = int'($urandom_range(0, 99));
		if (pick < 40) begin
			n = int'($urandom_range(0, 12));
			repeat (n) send_byte(text_byte());
			case ($urandom_range(0, 5))
			0: send_byte(B_CR);
			1: send_byte(B_LF);
			2: begin
				send_byte(B_CR);
				send_byte(B_LF);
			end
			3: begin
				send_byte(B_LF);
				send_byte(B_CR);
			end
			4: send_byte(B_EOT);
			default: begin
				send_byte(B_CR);
				send_byte(B_CR);
				send_byte(B_LF);
			end
			endcase
		end else if (pick < 60) begin
			send_byte(T_IAC);
			case ($urandom_range(0, 9))
			0: send_byte(T_IP);
			1: send_byte(T_EL);
			2: send_byte(T_AYT);
			3, 4: begin
				send_byte(T_DO);
				send_byte($urandom_range(0, 1) ? OPT_TM : OPT_SGA);
			end
			5: begin
				send_byte(T_DO);
				send_byte(8'($urandom_range(0, 255)));
			end
			6: begin
				n = int'($urandom_range(0, 2));
				send_byte(n == 0 ? T_WILL : (n == 1 ? T_WONT : T_DONT));
				send_byte(8'($urandom_range(0, 255)));
			end
			7: send_byte(T_IAC);
			default: send_byte(8'($urandom_range(0, 255)));
			endcase
		end else if (pick < 72) begin
			repeat ($urandom_range(1, 3))
				send_byte($urandom_range(0, 4) == 0 ? B_DEL
					: 8'($urandom_range(0, 31)));
		end else if (pick < 90) begin
			repeat ($urandom_range(1, 4))
				send_byte(8'($urandom_range(0, 255)));
		end else begin
			// Broken sequence: a terminator or another IAC where an option
			// or a command byte belongs.
			send_byte(T_IAC);
			if ($urandom_range(0, 1))
				send_byte(T_DO);
			case ($urandom_range(0, 3))
			0: send_byte(B_CR);
			1: send_byte(B_LF);
			2: send_byte(B_EOT);
			default: send_byte(T_IAC);
			endcase
		end
	endtask

	// Sender: reset, directed opening, random traffic with a line run up
	// to capacity in the middle, then drain and give the verdict.
	initial begin
		arst_n        <= 1'b0;
		rx_valid      <= 1'b0;
		rx_byte       <= 8'h00;
		bytes_sent    = 0;
		sender_steady = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Class boundaries: space is kept, 0x1F and DEL dropped, 0x80 and
		// 0xFE kept.
		send_byte(B_SPACE);
		send_byte(8'h1F);
		send_byte(B_DEL);
		send_byte(8'h80);
		send_byte(8'hFE);
		// Line ends after a terminator are swallowed; EOT never is.
		send_byte(B_CR);
		send_byte(B_LF);
		send_byte(B_CR);
		send_byte(B_EOT);
		// Every telnet command, an unknown DO option, an option skip that
		// eats an IAC, a doubled IAC, an unknown command, and logout last.
		send_byte(T_IAC); send_byte(T_EL);
		send_byte(T_IAC); send_byte(T_AYT);
		send_byte(T_IAC); send_byte(T_DO); send_byte(OPT_TM);
		send_byte(T_IAC); send_byte(T_DO); send_byte(OPT_SGA);
		send_byte(T_IAC); send_byte(T_DO); send_byte(8'h01);
		send_byte(T_IAC); send_byte(T_WONT); send_byte(T_IAC);
		send_byte(T_IAC); send_byte(T_IAC);
		send_byte(T_IAC); send_byte(8'h00);
		send_byte(T_IAC); send_byte(T_IP);

		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES / 2)
			send_random_sequence();

		// Capacity reached on an IAC: forced end with the telnet phase kept,
		// so the AYT that follows still counts as a command.
		send_long_line(int'(LINE_BYTES) - 1, T_IAC);
		send_byte(T_AYT);

		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES / 2)
			send_random_sequence();
		rx_valid <= 1'b0;

		// Drain, then let the input and result registers settle.
		@(posedge clk);
		while (words_waiting != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("tb: %0d words checked, %0d forced line ends, result kinds seen %b",
			words_checked, forced_seen, kinds_seen);
		$display("tb: text lines, telnet commands, swallowed line ends, noise, full lines");
		if (fails == 0 && words_waiting == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Receiver: stall for a random number of cycles before each word, with
	// steady stretches, and twice hold off long enough that the parser
	// backs up and stalls its input while the sender keeps offering.
	initial begin
		int hold;
		int taken;
		bit steady;
		res_stall <= 1'b0;
		taken  = 0;
		steady = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				steady = !steady;
			hold = steady ? 0 : int'($urandom_range(0, 7));
			if (taken == 120 || taken == 400)
				hold = 64;
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!(res_valid && !res_stall))
				@(posedge clk);
			taken++;
		end
	end

	// Watchdog: count cycles with no handshake on either channel.
	always @(posedge clk) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((rx_valid && !rx_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

endmodule
